FILE: design/dbwc_pkg.sv
// ----------------------------------------------------------------------------
// dbwc_pkg: shared types and constants of the delay-based window controller
// Register map, reset values, timeout codes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package dbwc_pkg;

  localparam int WINDOW_BITS_DEF = 10;

  localparam int RTT_W    = 33;
  localparam int CHANGE_W = 34;
  localparam int COUNT_W  = 11;

  // Register indexes on the configuration port (byte address = 4 * index).
  typedef enum logic [1:0] {
    REG_INITIAL_WINDOW  = 2'd0,
    REG_RTT_THRESHOLD   = 2'd1,
    REG_DELTA_THRESHOLD = 2'd2,
    REG_WINDOW_CAP      = 2'd3
  } reg_idx_e;

  localparam logic [9:0]  INITIAL_WINDOW_RST  = 10'd100;
  localparam logic [15:0] RTT_THRESHOLD_RST   = 16'd105;
  localparam logic [15:0] DELTA_THRESHOLD_RST = 16'd25;
  localparam logic [9:0]  WINDOW_CAP_RST      = 10'd48;

  localparam logic signed [RTT_W-1:0] RTT_AT_RESET = 33'sd100;

  localparam logic signed [CHANGE_W-1:0] CHANGE_HIGH = 34'sd125;
  localparam logic signed [CHANGE_W-1:0] CHANGE_LOW  = -34'sd100;

  localparam logic [7:0] TIMEOUT_LONG   = 8'd175;
  localparam logic [7:0] TIMEOUT_SHORT  = 8'd50;
  localparam logic [7:0] TIMEOUT_NORMAL = 8'd100;

  typedef struct packed {
    logic [15:0] rtt_threshold;
    logic [15:0] delta_threshold;
    logic [9:0]  window_cap;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/dbwc_update.sv
// ----------------------------------------------------------------------------
// dbwc_update: window and growth counter update for one acknowledgement
// Compares the new round-trip time and its change against the thresholds and
// produces the next window, the next growth count and the timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module dbwc_update #(
  parameter int WINDOW_BITS = dbwc_pkg::WINDOW_BITS_DEF
) (
  input  dbwc_pkg::cfg_t                          cfg_i,
  input  logic [WINDOW_BITS-1:0]                  window_i,
  input  logic [dbwc_pkg::COUNT_W-1:0]            count_i,
  input  logic signed [dbwc_pkg::RTT_W-1:0]       last_rtt_i,
  input  logic signed [dbwc_pkg::RTT_W-1:0]       rtt_i,
  output logic [WINDOW_BITS-1:0]                  window_o,
  output logic [dbwc_pkg::COUNT_W-1:0]            count_o,
  output logic [7:0]                              timeout_o
);
  import dbwc_pkg::*;

  // Common width for comparing window, cap and growth count.
  localparam int CW = (WINDOW_BITS > COUNT_W) ? WINDOW_BITS : COUNT_W;
  localparam logic [WINDOW_BITS-1:0] WINDOW_MAX = {WINDOW_BITS{1'b1}};

  logic signed [CHANGE_W-1:0] change;
  logic signed [CHANGE_W-1:0] rtt_x;
  logic signed [CHANGE_W-1:0] thr_s;
  logic signed [CHANGE_W-1:0] dth3_s;
  logic signed [CHANGE_W-1:0] ndth_s;
  logic [17:0]                dth3;
  logic [CW-1:0]              win_x;
  logic [CW-1:0]              cap_x;
  logic [CW-1:0]              cnt_x;
  logic [COUNT_W:0]           cnt_inc;
  logic [COUNT_W-1:0]         cnt_sat;
  logic [WINDOW_BITS:0]       win_p4;
  logic [WINDOW_BITS:0]       win_p2;
  logic                       shrink;
  logic                       grow;
  logic                       cut;

  assign rtt_x  = {rtt_i[RTT_W-1], rtt_i};
  assign change = rtt_x - {last_rtt_i[RTT_W-1], last_rtt_i};
  assign thr_s  = signed'({18'd0, cfg_i.rtt_threshold});
  assign dth3   = {2'b00, cfg_i.delta_threshold} + {1'b0, cfg_i.delta_threshold, 1'b0};
  assign dth3_s = signed'({16'd0, dth3});
  assign ndth_s = -signed'({18'd0, cfg_i.delta_threshold});

  assign win_x = CW'(window_i);
  assign cap_x = CW'(cfg_i.window_cap);

  assign cnt_inc = {1'b0, count_i} + (COUNT_W+1)'(2);
  assign cnt_sat = cnt_inc[COUNT_W] ? {COUNT_W{1'b1}} : cnt_inc[COUNT_W-1:0];
  assign cnt_x   = CW'(cnt_sat);

  assign win_p4 = {1'b0, window_i} + (WINDOW_BITS+1)'(4);
  assign win_p2 = {1'b0, window_i} + (WINDOW_BITS+1)'(2);

  assign shrink = (win_x > CW'(2)) && (rtt_x > thr_s);
  assign grow   = !shrink && (win_x < cap_x) && (rtt_x < thr_s);
  assign cut    = (win_x > CW'(4)) && (change > dth3_s);

  always_comb begin
    window_o = window_i;
    count_o  = count_i;
    if (shrink) begin
      if (cut) begin
        window_o = window_i - (window_i >> 2);
      end else begin
        window_o = window_i - WINDOW_BITS'(1);
      end
      count_o = '0;
    end else if (grow) begin
      count_o = cnt_sat;
      if (change < ndth_s) begin
        window_o = win_p4[WINDOW_BITS] ? WINDOW_MAX : win_p4[WINDOW_BITS-1:0];
        count_o  = '0;
      end else if (win_x <= cnt_x) begin
        window_o = win_p2[WINDOW_BITS] ? WINDOW_MAX : win_p2[WINDOW_BITS-1:0];
        count_o  = '0;
      end
    end
  end

  always_comb begin
    if (change > CHANGE_HIGH) begin
      timeout_o = TIMEOUT_LONG;
    end else if (change < CHANGE_LOW) begin
      timeout_o = TIMEOUT_SHORT;
    end else begin
      timeout_o = TIMEOUT_NORMAL;
    end
  end

endmodule

`default_nettype wire

FILE: design/delay_based_window_controller.sv
// ----------------------------------------------------------------------------
// delay_based_window_controller: congestion window from round-trip delay
// Each acknowledgement (send and arrival timestamps) updates the window and
// yields the window with a retransmit timeout.
// ----------------------------------------------------------------------------
//   The slave stream takes one acknowledgement per transfer, the send time in
//   tdata[31:0] and the arrival time in tdata[63:32]. The master stream gives
//   one result per acknowledgement, in order: window in tdata[9:0], timeout
//   in ms in tdata[17:10].
//   Throughput is one acknowledgement per cycle while results are taken:
//   the first stage forms the round-trip time, the second updates the
//   window state and loads the result register.
//   If the receiver stalls, the result register holds its transfer and an
//   empty first stage still takes one acknowledgement; once both stages are
//   full, s_axis_tready stays low until the result is taken.
//   Reset loads the register defaults, sets the window to the initial window,
//   clears the growth counter and sets the previous round-trip time to 100.
//   The APB port is to be written while the stream is idle (the block does
//   not enforce it); writing the initial window also reloads the current window.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_based_window_controller #(
  parameter int WINDOW_BITS = dbwc_pkg::WINDOW_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // send_time[31:0], ack_time[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // window[9:0], timeout[17:10], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dbwc_pkg::*;

  localparam logic [WINDOW_BITS-1:0] WINDOW_MAX = {WINDOW_BITS{1'b1}};
  localparam int LW = (WINDOW_BITS > 10) ? WINDOW_BITS : 10;

  logic [9:0]               initial_window_q;
  cfg_t                     cfg_q;
  logic [WINDOW_BITS-1:0]   window_q;
  logic [COUNT_W-1:0]       count_q;
  logic signed [RTT_W-1:0]  last_rtt_q;

  logic                     s1_valid_q;
  logic signed [RTT_W-1:0]  rtt_q;
  logic                     out_valid_q;
  logic [9:0]               out_window_q;
  logic [7:0]               out_timeout_q;

  logic                     cfg_wr;
  reg_idx_e                 cfg_idx;
  logic                     out_free;
  logic                     s1_move;
  logic                     in_take;
  logic [WINDOW_BITS-1:0]   window_d;
  logic [COUNT_W-1:0]       count_d;
  logic [7:0]               timeout_d;
  logic [WINDOW_BITS-1:0]   init_clamped;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_INITIAL_WINDOW:  prdata = {22'd0, initial_window_q};
      REG_RTT_THRESHOLD:   prdata = {16'd0, cfg_q.rtt_threshold};
      REG_DELTA_THRESHOLD: prdata = {16'd0, cfg_q.delta_threshold};
      REG_WINDOW_CAP:      prdata = {22'd0, cfg_q.window_cap};
      default:             prdata = '0;
    endcase
  end

  // The written initial window is clamped to what the window register holds.
  assign init_clamped = (LW'(pwdata[9:0]) > LW'(WINDOW_MAX)) ?
                        WINDOW_MAX : WINDOW_BITS'(LW'(pwdata[9:0]));

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  dbwc_update #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_update (
    .cfg_i      (cfg_q),
    .window_i   (window_q),
    .count_i    (count_q),
    .last_rtt_i (last_rtt_q),
    .rtt_i      (rtt_q),
    .window_o   (window_d),
    .count_o    (count_d),
    .timeout_o  (timeout_d)
  );

  // Configuration registers and window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_window_q      <= INITIAL_WINDOW_RST;
      cfg_q.rtt_threshold   <= RTT_THRESHOLD_RST;
      cfg_q.delta_threshold <= DELTA_THRESHOLD_RST;
      cfg_q.window_cap      <= WINDOW_CAP_RST;
      window_q              <= (LW'(INITIAL_WINDOW_RST) > LW'(WINDOW_MAX)) ?
                               WINDOW_MAX : WINDOW_BITS'(LW'(INITIAL_WINDOW_RST));
      count_q               <= '0;
      last_rtt_q            <= RTT_AT_RESET;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_INITIAL_WINDOW: begin
            initial_window_q <= pwdata[9:0];
            window_q         <= init_clamped;
          end
          REG_RTT_THRESHOLD:   cfg_q.rtt_threshold   <= pwdata[15:0];
          REG_DELTA_THRESHOLD: cfg_q.delta_threshold <= pwdata[15:0];
          REG_WINDOW_CAP:      cfg_q.window_cap      <= pwdata[9:0];
          default: ;
        endcase
      end else if (s1_move) begin
        window_q   <= window_d;
        count_q    <= count_d;
        last_rtt_q <= rtt_q;
      end
    end
  end

  // Pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      rtt_q <= signed'({1'b0, s_axis_tdata[63:32]}) - signed'({1'b0, s_axis_tdata[31:0]});
    end
    if (s1_move) begin
      out_window_q  <= 10'(window_d);
      out_timeout_q <= timeout_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_timeout_q, out_window_q};

endmodule

`default_nettype wire
